### hdl/lucp_pkg.sv
// ----------------------------------------------------------------------------
// lucp_pkg: shared types and constants for the least-used connection pool
// Status codes, update commands and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lucp_pkg;

    localparam int DEF_ENTRIES  = 16;
    localparam int DEF_KEY_BITS = 48;
    localparam int DEF_ID_BITS  = 16;

    // Fixed port widths
    localparam int KEY_IN_BITS  = 48;
    localparam int ID_OUT_BITS  = 16;
    localparam int CNT_OUT_BITS = 5;
    localparam int USE_BITS     = 16;
    localparam int MAX_BITS     = 8;

    localparam logic [USE_BITS-1:0] USE_MAX = '1;
    localparam logic [MAX_BITS-1:0] MAX_RESET = 8'd1;

    localparam logic FUNC_ACQUIRE = 1'b0;
    localparam logic FUNC_DETACH  = 1'b1;

    typedef enum logic [2:0] {
        ST_REUSED         = 3'd0,
        ST_INSERTED       = 3'd1,
        ST_CONNECT_FAILED = 3'd2,
        ST_TABLE_FULL     = 3'd3,
        ST_DETACHED       = 3'd4,
        ST_NOT_FOUND      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_REUSE,
        UPD_INSERT,
        UPD_DETACH
    } t_upd;

    // controller -> datapath
    typedef struct packed {
        logic    load;     // latch request, restart scan
        logic    step;     // examine one table entry
        logic    emit;     // apply update, register result beat
        t_upd    upd;
        t_status status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic func;
        logic scan_end;
        logic reuse_ok;
        logic connect_ok;
        logic full;
        logic found;
    } t_stat;

endpackage

### hdl/least_used_connection_pool_core.sv
// ----------------------------------------------------------------------------
// least_used_connection_pool_core: least-used connection pool, top level
// Ordered table of open connections with per-destination sharing limit.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low; busy then
// stays high until the table is updated. Each request gives exactly one
// result beat: o_done is high for one cycle with the result fields valid, and
// the receiver cannot stall it. The table is scanned one entry per cycle from
// the head, visiting, for an acquire, the live entry count plus one, capped
// at ENTRIES; for a detach, the position of the hit plus one (or the same
// as an acquire on a miss). The result beat is on the ports in the first
// cycle with busy low, so a new request can be taken at the same edge that
// takes the result. max_per_destination is written over the APB port
// (register 0, address 0) and should only change while the block is idle.
// ----------------------------------------------------------------------------
module least_used_connection_pool_core
    import lucp_pkg::*;
#(
    parameter int ENTRIES  = DEF_ENTRIES,
    parameter int KEY_BITS = DEF_KEY_BITS,
    parameter int ID_BITS  = DEF_ID_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    // config port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,

    // request
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_func,
    input  logic [KEY_IN_BITS-1:0]  i_dest_key,
    input  logic [15:0]             i_conn_id,
    input  logic                    i_connect_ok,

    // result
    output logic                    o_done,
    output logic [2:0]              o_status,
    output logic [ID_OUT_BITS-1:0]  o_chosen_id,
    output logic [CNT_OUT_BITS-1:0] o_match_count,
    output logic [USE_BITS-1:0]     o_use_count
);

    logic [MAX_BITS-1:0] r_max_per_dest;
    logic                cfg_wr;
    logic                ctrl_busy;
    t_cmd                cmd;
    t_stat               stat;

    // Config register: word 0 only, upper addresses read as zero.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_per_dest <= MAX_RESET;
        end else if (cfg_wr && !paddr[2]) begin
            r_max_per_dest <= pwdata[MAX_BITS-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {{(32 - MAX_BITS){1'b0}}, r_max_per_dest};

    // Sequencer: idle -> scan (one entry per cycle) -> decide/update.
    lucp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy)
    );

    // Table, scan trackers (count, least-used pick, detach hit) and result regs.
    lucp_dpath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS),
        .ID_BITS  (ID_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_max         (r_max_per_dest),
        .i_func        (i_func),
        .i_dest_key    (i_dest_key),
        .i_conn_id     (i_conn_id),
        .i_connect_ok  (i_connect_ok),
        .o_stat        (stat),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_chosen_id   (o_chosen_id),
        .o_match_count (o_match_count),
        .o_use_count   (o_use_count)
    );

    assign busy = ctrl_busy;

`ifndef SYNTHESIS
    // accepted request keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // a result beat only follows a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result beat without a request in flight");

    // one beat per request, never two in a row
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back result beats");

    // a fresh entry always reports one use
    a_insert_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == ST_INSERTED) |-> (o_use_count == USE_BITS'(1)))
        else $error("inserted entry use count not one");

    // detach results never carry a match count
    a_detach_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && ((o_status == ST_DETACHED) || (o_status == ST_NOT_FOUND))
        |-> (o_match_count == '0))
        else $error("detach result with nonzero match count");
`endif

endmodule

### hdl/lucp_ctrl.sv
// ----------------------------------------------------------------------------
// lucp_ctrl: sequencer for the connection pool
// Runs load, table scan and decide phases; picks the update and status code.
// ----------------------------------------------------------------------------
module lucp_ctrl
    import lucp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.emit   = 1'b0;
        o_cmd.upd    = UPD_NONE;
        o_cmd.status = ST_NOT_FOUND;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
                if (i_stat.func == FUNC_ACQUIRE) begin
                    if (i_stat.reuse_ok) begin
                        o_cmd.upd    = UPD_REUSE;
                        o_cmd.status = ST_REUSED;
                    end else if (!i_stat.connect_ok) begin
                        o_cmd.status = ST_CONNECT_FAILED;
                    end else if (i_stat.full) begin
                        o_cmd.status = ST_TABLE_FULL;
                    end else begin
                        o_cmd.upd    = UPD_INSERT;
                        o_cmd.status = ST_INSERTED;
                    end
                end else if (i_stat.found) begin
                    o_cmd.upd    = UPD_DETACH;
                    o_cmd.status = ST_DETACHED;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

### hdl/lucp_dpath.sv
// ----------------------------------------------------------------------------
// lucp_dpath: connection table and scan datapath
// Ordered entry table, one-entry-per-cycle scan, table update, result beat.
// ----------------------------------------------------------------------------
module lucp_dpath
    import lucp_pkg::*;
#(
    parameter int ENTRIES  = DEF_ENTRIES,
    parameter int KEY_BITS = DEF_KEY_BITS,
    parameter int ID_BITS  = DEF_ID_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [MAX_BITS-1:0]     i_max,
    input  logic                    i_func,
    input  logic [KEY_IN_BITS-1:0]  i_dest_key,
    input  logic [15:0]             i_conn_id,
    input  logic                    i_connect_ok,
    output t_stat                   o_stat,
    output logic                    o_done,
    output logic [2:0]              o_status,
    output logic [ID_OUT_BITS-1:0]  o_chosen_id,
    output logic [CNT_OUT_BITS-1:0] o_match_count,
    output logic [USE_BITS-1:0]     o_use_count
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    // table
    logic [ENTRIES-1:0]  r_valid;
    logic [KEY_BITS-1:0] r_dest [ENTRIES];
    logic [ID_BITS-1:0]  r_id   [ENTRIES];
    logic [USE_BITS-1:0] r_uses [ENTRIES];

    // request
    logic                r_func;
    logic [KEY_BITS-1:0] r_key;
    logic [ID_BITS-1:0]  r_in_id;
    logic                r_ok;

    // scan
    logic [IW-1:0]       r_idx;
    logic [CW-1:0]       r_cnt;
    logic                r_best_v;
    logic [IW-1:0]       r_best_idx;
    logic [USE_BITS-1:0] r_best_uses;
    logic [ID_BITS-1:0]  r_best_id;
    logic                r_found;
    logic [IW-1:0]       r_found_idx;
    logic [USE_BITS-1:0] r_found_uses;

    // result
    logic                    r_done;
    t_status                 r_status;
    logic [ID_OUT_BITS-1:0]  r_chosen_id;
    logic [CNT_OUT_BITS-1:0] r_match_count;
    logic [USE_BITS-1:0]     r_use_count;

    logic [KEY_BITS+KEY_IN_BITS-1:0] key_ext;
    logic [ID_BITS+15:0]             id_in_ext;
    logic [ID_BITS+ID_OUT_BITS-1:0]  id_best_ext, id_req_ext;
    logic [CW+CNT_OUT_BITS-1:0]      cnt_ext;
    logic                            cur_valid, key_hit, id_hit;
    logic [USE_BITS-1:0]             cur_uses, best_next;

    assign key_ext   = {{KEY_BITS{1'b0}}, i_dest_key};
    assign id_in_ext = {{ID_BITS{1'b0}}, i_conn_id};
    assign id_best_ext = {{ID_OUT_BITS{1'b0}}, r_best_id};
    assign id_req_ext  = {{ID_OUT_BITS{1'b0}}, r_in_id};
    assign cnt_ext     = {{CNT_OUT_BITS{1'b0}}, r_cnt};

    assign cur_valid = r_valid[r_idx];
    assign cur_uses  = r_uses[r_idx];
    assign key_hit   = cur_valid && (r_dest[r_idx] == r_key);
    assign id_hit    = cur_valid && (r_id[r_idx] == r_in_id);
    assign best_next = (r_best_uses == USE_MAX) ? r_best_uses : r_best_uses + 1'b1;

    // entries are packed at the head, so the first empty slot ends the scan
    assign o_stat.func       = r_func;
    assign o_stat.scan_end   = !cur_valid || (r_idx == LAST) ||
                               ((r_func == FUNC_DETACH) && id_hit);
    assign o_stat.reuse_ok   = r_best_v &&
                               ({{MAX_BITS{1'b0}}, r_cnt} >= {{CW{1'b0}}, i_max});
    assign o_stat.connect_ok = r_ok;
    assign o_stat.full       = r_valid[ENTRIES-1];
    assign o_stat.found      = r_found;

    // scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_key    <= key_ext[KEY_BITS-1:0];
            r_in_id  <= id_in_ext[ID_BITS-1:0];
            r_ok     <= i_connect_ok;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_best_v <= 1'b0;
            r_found  <= 1'b0;
        end else if (i_cmd.step) begin
            if ((r_func == FUNC_ACQUIRE) && key_hit) begin
                r_cnt <= r_cnt + CW'(1);
                // strict compare keeps the entry nearest the head on a tie
                if (!r_best_v || (cur_uses < r_best_uses)) begin
                    r_best_v    <= 1'b1;
                    r_best_idx  <= r_idx;
                    r_best_uses <= cur_uses;
                    r_best_id   <= r_id[r_idx];
                end
            end
            if ((r_func == FUNC_DETACH) && id_hit) begin
                r_found      <= 1'b1;
                r_found_idx  <= r_idx;
                r_found_uses <= cur_uses;
            end
            if (!o_stat.scan_end) begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.emit) begin
            case (i_cmd.upd)
                UPD_INSERT: begin
                    r_valid <= {r_valid[ENTRIES-2:0], 1'b1};
                end
                UPD_DETACH: begin
                    for (int k = 0; k < ENTRIES - 1; k++) begin
                        if (IW'(k) >= r_found_idx) begin
                            r_valid[k] <= r_valid[k+1];
                        end
                    end
                    r_valid[ENTRIES-1] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // table payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            case (i_cmd.upd)
                UPD_REUSE: begin
                    r_uses[r_best_idx] <= best_next;
                end
                UPD_INSERT: begin
                    for (int k = 1; k < ENTRIES; k++) begin
                        r_dest[k] <= r_dest[k-1];
                        r_id[k]   <= r_id[k-1];
                        r_uses[k] <= r_uses[k-1];
                    end
                    r_dest[0] <= r_key;
                    r_id[0]   <= r_in_id;
                    r_uses[0] <= USE_BITS'(1);
                end
                UPD_DETACH: begin
                    for (int k = 0; k < ENTRIES - 1; k++) begin
                        if (IW'(k) >= r_found_idx) begin
                            r_dest[k] <= r_dest[k+1];
                            r_id[k]   <= r_id[k+1];
                            r_uses[k] <= r_uses[k+1];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= i_cmd.status;
            case (i_cmd.status)
                ST_REUSED: begin
                    r_chosen_id   <= id_best_ext[ID_OUT_BITS-1:0];
                    r_match_count <= cnt_ext[CNT_OUT_BITS-1:0];
                    r_use_count   <= best_next;
                end
                ST_INSERTED: begin
                    r_chosen_id   <= id_req_ext[ID_OUT_BITS-1:0];
                    r_match_count <= cnt_ext[CNT_OUT_BITS-1:0];
                    r_use_count   <= USE_BITS'(1);
                end
                ST_CONNECT_FAILED, ST_TABLE_FULL: begin
                    r_chosen_id   <= '0;
                    r_match_count <= cnt_ext[CNT_OUT_BITS-1:0];
                    r_use_count   <= '0;
                end
                ST_DETACHED: begin
                    r_chosen_id   <= id_req_ext[ID_OUT_BITS-1:0];
                    r_match_count <= '0;
                    r_use_count   <= r_found_uses;
                end
                default: begin
                    r_chosen_id   <= '0;
                    r_match_count <= '0;
                    r_use_count   <= '0;
                end
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_chosen_id   = r_chosen_id;
    assign o_match_count = r_match_count;
    assign o_use_count   = r_use_count;

endmodule

### test/tb_least_used_connection_pool_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_least_used_connection_pool_core: self-checking bench for the conn pool
// Drives acquire/detach beats with random gaps, predicts every result beat
// from a private copy of the connection table and compares field by field.
// ----------------------------------------------------------------------------

import lucp_pkg::*;

typedef struct {
    t_status                 status;
    logic [ID_OUT_BITS-1:0]  chosen_id;
    logic [CNT_OUT_BITS-1:0] match_count;
    logic [USE_BITS-1:0]     use_count;
} pool_result_t;

// Shadow connection table plus the queue of result beats still owed.
class conn_pool_scoreboard;
    bit                      slot_valid[DEF_ENTRIES];
    logic [KEY_IN_BITS-1:0]  slot_dest[DEF_ENTRIES];
    logic [ID_OUT_BITS-1:0]  slot_id[DEF_ENTRIES];
    logic [USE_BITS-1:0]     slot_uses[DEF_ENTRIES];
    logic [MAX_BITS-1:0]     share_limit;
    pool_result_t            owed_q[$];
    int                      mismatches;

    function new();
        share_limit = MAX_RESET;
        mismatches  = 0;
        foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_dest[i]  = '0;
            slot_id[i]    = '0;
            slot_uses[i]  = '0;
        end
    endfunction

    function pool_result_t make_result(t_status st, logic [ID_OUT_BITS-1:0] id,
                                       int hits, logic [USE_BITS-1:0] uses);
        pool_result_t r;
        r.status      = st;
        r.chosen_id   = id;
        r.match_count = hits[CNT_OUT_BITS-1:0];
        r.use_count   = uses;
        return r;
    endfunction

    function void copy_slot(int to, int from);
        slot_valid[to] = slot_valid[from];
        slot_dest[to]  = slot_dest[from];
        slot_id[to]    = slot_id[from];
        slot_uses[to]  = slot_uses[from];
    endfunction

    function int live_entries();
        int n;
        n = 0;
        foreach (slot_valid[i]) n += slot_valid[i];
        return n;
    endfunction

    // Accepted request beat: update the shadow table, queue the result.
    function void note_request(logic func, logic [KEY_IN_BITS-1:0] key,
                               logic [ID_OUT_BITS-1:0] id, logic ok);
        int hits;
        int best;
        hits = 0;
        best = -1;
        if (func == FUNC_ACQUIRE) begin
            for (int i = 0; i < DEF_ENTRIES; i++) begin
                if (slot_valid[i] && slot_dest[i] == key) begin
                    hits++;
                    // strict compare: ties stay with the entry nearest the head
                    if (best < 0 || slot_uses[best] > slot_uses[i]) best = i;
                end
            end
            if (best >= 0 && hits >= share_limit) begin
                if (slot_uses[best] != USE_MAX) slot_uses[best]++;
                owed_q.push_back(make_result(ST_REUSED, slot_id[best], hits,
                                             slot_uses[best]));
            end else if (!ok) begin
                owed_q.push_back(make_result(ST_CONNECT_FAILED, '0, hits, '0));
            end else if (slot_valid[DEF_ENTRIES-1]) begin
                owed_q.push_back(make_result(ST_TABLE_FULL, '0, hits, '0));
            end else begin
                for (int i = DEF_ENTRIES - 1; i > 0; i--) copy_slot(i, i - 1);
                slot_valid[0] = 1'b1;
                slot_dest[0]  = key;
                slot_id[0]    = id;
                slot_uses[0]  = 16'd1;
                owed_q.push_back(make_result(ST_INSERTED, id, hits, 16'd1));
            end
        end else begin
            for (int i = 0; i < DEF_ENTRIES; i++)
                if (best < 0 && slot_valid[i] && slot_id[i] == id) best = i;
            if (best >= 0) begin
                owed_q.push_back(make_result(ST_DETACHED, id, 0, slot_uses[best]));
                for (int k = best; k < DEF_ENTRIES - 1; k++) copy_slot(k, k + 1);
                slot_valid[DEF_ENTRIES-1] = 1'b0;
                slot_dest[DEF_ENTRIES-1]  = '0;
                slot_id[DEF_ENTRIES-1]    = '0;
                slot_uses[DEF_ENTRIES-1]  = '0;
            end else begin
                owed_q.push_back(make_result(ST_NOT_FOUND, '0, 0, '0));
            end
        end
    endfunction

    function void check_result(pool_result_t got);
        pool_result_t want;
        if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: result beat with none owed, status %0d id %h",
                         got.status, got.chosen_id);
        end else begin
            want = owed_q.pop_front();
            if (got.status !== want.status || got.chosen_id !== want.chosen_id ||
                got.match_count !== want.match_count ||
                got.use_count !== want.use_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp st %0d id %h cnt %0d uses %0d, ",
                              "got st %0d id %h cnt %0d uses %0d"},
                             want.status, want.chosen_id, want.match_count,
                             want.use_count, got.status, got.chosen_id,
                             got.match_count, got.use_count);
            end
        end
    endfunction
endclass

module tb_least_used_connection_pool_core;

    localparam int REG_MAX_PER_DEST = 0;       // register index, byte address 4*index
    localparam int WATCHDOG_LIMIT   = 2000;    // quiet cycles before giving up
    localparam int SETTLE_CYCLES    = 2 * DEF_ENTRIES + 8;
    localparam int PHASE_ITEMS      = 255;
    localparam int HOT_KEYS         = 4;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [2:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    start;
    logic                    busy;
    logic                    i_func;
    logic [KEY_IN_BITS-1:0]  i_dest_key;
    logic [15:0]             i_conn_id;
    logic                    i_connect_ok;
    logic                    o_done;
    logic [2:0]              o_status;
    logic [ID_OUT_BITS-1:0]  o_chosen_id;
    logic [CNT_OUT_BITS-1:0] o_match_count;
    logic [USE_BITS-1:0]     o_use_count;

    conn_pool_scoreboard     pool_sb;
    int                      idle_cycles;
    int                      burst_left;
    logic [KEY_IN_BITS-1:0]  hot_key[HOT_KEYS];
    int                      phase_limit[6] = '{255, 2, 3, 1, 4, 16};

    least_used_connection_pool_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_dest_key    (i_dest_key),
        .i_conn_id     (i_conn_id),
        .i_connect_ok  (i_connect_ok),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_chosen_id   (o_chosen_id),
        .o_match_count (o_match_count),
        .o_use_count   (o_use_count)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Monitor. Inputs only move on the falling edge, so everything read here
    // is the value that was stable through the cycle ending at this edge.
    // Request beat: start high and busy low. Result beat: o_done high.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                pool_sb.note_request(i_func, i_dest_key, i_conn_id, i_connect_ok);
            if (o_done)
                pool_sb.check_result(pool_sb.make_result(t_status'(o_status),
                    o_chosen_id, int'(o_match_count), o_use_count));
        end
    end

    // Watchdog: any beat or register write counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [KEY_IN_BITS-1:0] rand_key();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // All drive tasks are entered and left on a falling edge.
    task automatic send_beat(logic func, logic [KEY_IN_BITS-1:0] key,
                             logic [15:0] id, logic ok, int gap);
        repeat (gap) @(negedge i_clk);
        i_func       = func;
        i_dest_key   = key;
        i_conn_id    = id;
        i_connect_ok = ok;
        start        = 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // Random gap before each beat, with occasional back-to-back bursts.
    task automatic send_item(logic func, logic [KEY_IN_BITS-1:0] key,
                             logic [15:0] id, logic ok);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(10, 30);
        end
        send_beat(func, key, id, ok, gap);
    endtask

    task automatic wait_drained();
        while (pool_sb.owed_q.size() != 0) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(int index, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 3'(4 * index);
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (index == REG_MAX_PER_DEST) pool_sb.share_limit = value[MAX_BITS-1:0];
    endtask

    // Mostly acquires on a few hot keys so per-key counts climb and the
    // table fills; detaches mostly name live ids and lean harder when the
    // table is nearly full. A sprinkle of fresh keys, stray ids, duplicate
    // ids and failed connects makes up the noise.
    task automatic run_random_phase(int n_items);
        int                     live;
        int                     detach_pct;
        logic                   func;
        logic [KEY_IN_BITS-1:0] key;
        logic [15:0]            id;
        logic                   ok;
        for (int k = 0; k < HOT_KEYS - 1; k++) hot_key[k] = rand_key();
        // near miss: one bit away from another hot key
        hot_key[HOT_KEYS-1] = hot_key[0] ^ (48'd1 << $urandom_range(0, 47));
        repeat (n_items) begin
            live       = pool_sb.live_entries();
            detach_pct = (live >= DEF_ENTRIES - 2) ? 55 : (live <= 2) ? 10 : 30;
            ok         = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 99) < detach_pct) begin
                func = FUNC_DETACH;
                key  = rand_key();
                if (live > 0 && $urandom_range(0, 3) != 0)
                    id = pool_sb.slot_id[$urandom_range(0, live - 1)];
                else
                    id = 16'($urandom);
            end else begin
                func = FUNC_ACQUIRE;
                key  = ($urandom_range(0, 9) == 0) ? rand_key()
                                                   : hot_key[$urandom_range(0, HOT_KEYS - 1)];
                if (live > 0 && $urandom_range(0, 19) == 0)
                    id = pool_sb.slot_id[$urandom_range(0, live - 1)];
                else
                    id = 16'($urandom);
            end
            send_item(func, key, id, ok);
            // now and then hold off until the block has answered everything
            if ($urandom_range(0, 63) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        logic [KEY_IN_BITS-1:0] shared_key;
        pool_sb      = new();
        burst_left   = 0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        i_func       = FUNC_ACQUIRE;
        i_dest_key   = '0;
        i_conn_id    = '0;
        i_connect_ok = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed: reset limit of 1 ---
        send_item(FUNC_DETACH,  '0, 16'hFFFF, 1'b1);    // empty table: not found
        send_item(FUNC_ACQUIRE, '0, 16'h0000, 1'b0);    // connect failed
        send_item(FUNC_ACQUIRE, '0, 16'h0000, 1'b1);    // insert at head
        send_item(FUNC_ACQUIRE, '0, 16'h1234, 1'b1);    // limit reached: reuse
        send_item(FUNC_ACQUIRE, '1, 16'hFFFF, 1'b1);    // all-ones key and id
        send_item(FUNC_DETACH,  '1, 16'h0000, 1'b0);    // detach ignores key/ok

        // --- directed: widest limit, fill the table on one key ---
        wait_drained();
        write_reg(REG_MAX_PER_DEST, 32'd255);
        shared_key = 48'hA5A5_5A5A_F00F;
        for (int i = 0; i < DEF_ENTRIES - 2; i++)
            send_item(FUNC_ACQUIRE, shared_key, 16'h8000 + 16'(i), 1'b1);
        send_item(FUNC_ACQUIRE, shared_key, 16'h8001, 1'b1);   // duplicate id
        // table now full, all but the oldest entry on the same key
        send_item(FUNC_ACQUIRE, shared_key, 16'h7777, 1'b0);   // failed and full: failed wins
        send_item(FUNC_ACQUIRE, shared_key, 16'h7777, 1'b1);   // table full
        send_item(FUNC_DETACH,  '0, 16'h8001, 1'b1);           // nearest-head duplicate goes
        send_item(FUNC_DETACH,  '0, 16'h8000, 1'b1);           // oldest shared-key entry

        // --- directed: limit of zero ---
        wait_drained();
        write_reg(REG_MAX_PER_DEST, 32'd0);
        send_item(FUNC_ACQUIRE, 48'h0000_0000_0001, 16'h4242, 1'b1);  // no match: insert
        send_item(FUNC_ACQUIRE, 48'h0000_0000_0001, 16'h4343, 1'b1);  // one match: reuse

        // --- random phases, one limit each ---
        foreach (phase_limit[p]) begin
            wait_drained();
            write_reg(REG_MAX_PER_DEST,
                      (p == 5) ? 32'($urandom_range(5, 255)) : 32'(phase_limit[p]));
            run_random_phase(PHASE_ITEMS);
        end

        // drain, then give a stray beat time to show up
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (pool_sb.mismatches == 0 && pool_sb.owed_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
